@@ src/tgasd_pkg.sv @@
// Package: constants and status codes of the TGA stream decoder.
package tgasd_pkg;

	localparam int MAX_DIM     = 16384;
	localparam int MAP_ENTRIES = 256;
	localparam int HDR_LEN     = 18;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int PIX_W  = 2 * DIM_W;
	localparam int MAP_W  = $clog2(MAP_ENTRIES + 1);
	localparam int ADDR_W = $clog2(MAP_ENTRIES);
	localparam int CNT_W  = (MAP_W > 5) ? MAP_W : 5;

	typedef enum logic [3:0] {
		ST_HDR_OK    = 4'd0,
		ST_RUN       = 4'd1,
		ST_FINAL     = 4'd2,
		ST_BAD_TYPE  = 4'd3,
		ST_BAD_SIZE  = 4'd4,
		ST_BAD_DEPTH = 4'd5,
		ST_BAD_MAP   = 4'd6,
		ST_MAP_BIG   = 4'd7,
		ST_OVERFLOW  = 4'd8,
		ST_BAD_INDEX = 4'd9,
		ST_TRUNC     = 4'd10
	} status_t;

endpackage

@@ src/tgasd_if.sv @@
// Stream interfaces: file bytes in, decoded words out.
interface tgasd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, data_byte, end_of_file, input ready);
	modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

interface tgasd_pixel_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [7:0]  chan_zero;
	logic [7:0]  chan_one;
	logic [7:0]  chan_two;
	logic [7:0]  chan_three;
	logic [2:0]  channel_count;
	logic [7:0]  run_length;
	logic [14:0] image_width;
	logic [14:0] image_height;

	modport source (output valid, status, chan_zero, chan_one, chan_two, chan_three,
		channel_count, run_length, image_width, image_height, input ready);
	modport sink (input valid, status, chan_zero, chan_one, chan_two, chan_three,
		channel_count, run_length, image_width, image_height, output ready);
endinterface

@@ src/tgasd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module tgasd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ src/tga_stream_decoder_unit.sv @@
// Top level of the TGA stream decoder: header parse, palette load, RLE/raw pixel decode.
// Each output word is registered in stage 1 and then in the stage-2 output register.
// Throughput: one byte per cycle while the output is not stalled; palette lookups use the registered RAM read port.
// A word stalled at the output holds one more in the stage-1 register before input stalls.
// arst_n clears all control state; the palette RAM is not cleared.
// After the end_of_file byte the decoder returns to header parsing.
module tga_stream_decoder_unit (
	input  logic clk,
	input  logic arst_n,
	tgasd_byte_if.sink    byte_in,
	tgasd_pixel_if.source pixel_out
);
	import tgasd_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER, PH_ID, PH_MAP, PH_PKT, PH_PIX, PH_DONE
	} phase_t;

	phase_t            phase_q, n_phase;
	logic [CNT_W-1:0]  cnt_q, n_cnt;
	logic [3:0]        kind_q, n_kind;
	logic [7:0]        id_left_q, n_id_left;
	logic [15:0]       pal_first_q, n_pal_first;
	logic [15:0]       pal_len_q, n_pal_len;
	logic [2:0]        peb_q, n_peb;
	logic [2:0]        bpp_q, n_bpp;
	logic [15:0]       width_q, n_width;
	logic [15:0]       height_q, n_height;
	logic [31:0]       asm_q, n_asm;
	logic [1:0]        bidx_q, n_bidx;
	logic [7:0]        pkt_left_q, n_pkt_left;
	logic              pkt_run_q, n_pkt_run;
	logic [PIX_W-1:0]  pix_left_q, n_pix_left;
	logic              dims_q, n_dims;

	logic              acc, emit, lookup, we_c, re_c, go_mop, go_map, go_pix, mapped;
	status_t           st, hdr_st;
	logic [7:0]        b;
	logic [7:0]        ch0, ch1, ch2, ch3, rl;
	logic [2:0]        cc;
	logic [14:0]       ow, oh;
	logic [31:0]       v, wd;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [16:0]       idx;
	logic [PIX_W-1:0]  prod;
	logic [7:0]        cnt8;
	logic              bad;
	logic [31:0]       rdata;

	logic              vld_s1, vld_s2, s1_adv;
	status_t           st_s1;
	logic [7:0]        ch0_s1, ch1_s1, ch2_s1, ch3_s1, rl_s1;
	logic [2:0]        cc_s1;
	logic [14:0]       w_s1, h_s1;
	logic              lk_s1;
	status_t           st_s2;
	logic [7:0]        ch0_s2, ch1_s2, ch2_s2, ch3_s2, rl_s2;
	logic [2:0]        cc_s2;
	logic [14:0]       w_s2, h_s2;

	function automatic status_t check_hdr(input logic [3:0] kind, input logic [15:0] w,
			input logic [15:0] h, input logic [2:0] bpp, input logic [15:0] plen,
			input logic [2:0] peb);
		logic is_map;
		is_map = (kind == 4'd1) || (kind == 4'd9);
		priority if (kind == 4'd0) begin
			return ST_BAD_TYPE;
		end else if (w == 16'd0 || w > 16'(MAX_DIM) || h == 16'd0 || h > 16'(MAX_DIM)) begin
			return ST_BAD_SIZE;
		end else if (bpp == 3'd0) begin
			return ST_BAD_DEPTH;
		end else if (is_map && (bpp != 3'd1 || plen == 16'd0 || peb == 3'd0)) begin
			return ST_BAD_MAP;
		end else if (is_map && plen > 16'(MAP_ENTRIES)) begin
			return ST_MAP_BIG;
		end else begin
			return ST_HDR_OK;
		end
	endfunction

	assign acc    = byte_in.valid && byte_in.ready;
	assign b      = byte_in.data_byte;
	assign mapped = (kind_q == 4'd1) || (kind_q == 4'd9);
	assign prod   = PIX_W'(width_q[DIM_W-1:0]) * PIX_W'(height_q[DIM_W-1:0]);
	assign hdr_st = check_hdr(kind_q, width_q, height_q, bpp_q, pal_len_q, peb_q);
	assign v      = asm_q | (32'(b) << {bidx_q, 3'b000});
	assign idx    = {1'b0, pal_first_q} + 17'(b);

	always_comb begin
		n_phase = phase_q; n_cnt = cnt_q; n_kind = kind_q; n_id_left = id_left_q;
		n_pal_first = pal_first_q; n_pal_len = pal_len_q; n_peb = peb_q; n_bpp = bpp_q;
		n_width = width_q; n_height = height_q; n_asm = asm_q; n_bidx = bidx_q;
		n_pkt_left = pkt_left_q; n_pkt_run = pkt_run_q; n_pix_left = pix_left_q;
		n_dims = dims_q;
		emit = 1'b0; st = ST_HDR_OK; lookup = 1'b0;
		ch0 = '0; ch1 = '0; ch2 = '0; ch3 = '0; cc = '0; rl = '0;
		we_c = 1'b0; re_c = 1'b0; wd = v; waddr = cnt_q[ADDR_W-1:0];
		raddr = idx[ADDR_W-1:0];
		go_mop = 1'b0; go_map = 1'b0; go_pix = 1'b0; bad = 1'b0;
		cnt8 = 8'(b[6:0]) + 8'd1;

		unique case (phase_q)
			PH_HEADER: begin
				n_cnt = cnt_q + CNT_W'(1);
				unique case (cnt_q[4:0])
					5'd0:  n_id_left = b;
					5'd2:  n_kind = (b == 8'd1 || b == 8'd2 || b == 8'd3 || b == 8'd9 ||
						b == 8'd10 || b == 8'd11) ? b[3:0] : 4'd0;
					5'd3:  n_pal_first = {8'd0, b};
					5'd4:  n_pal_first = {b, pal_first_q[7:0]};
					5'd5:  n_pal_len = {8'd0, b};
					5'd6:  n_pal_len = {b, pal_len_q[7:0]};
					5'd7:  n_peb = (b == 8'd8 || b == 8'd16 || b == 8'd24 || b == 8'd32) ?
						b[5:3] : 3'd0;
					5'd12: n_width = {8'd0, b};
					5'd13: n_width = {b, width_q[7:0]};
					5'd14: n_height = {8'd0, b};
					5'd15: n_height = {b, height_q[7:0]};
					5'd16: n_bpp = (b == 8'd8) ? 3'd1 : (b == 8'd24) ? 3'd3 :
						(b == 8'd32) ? 3'd4 : 3'd0;
					default: ;
				endcase
				if (cnt_q == CNT_W'(HDR_LEN - 1)) begin
					emit = 1'b1;
					st   = hdr_st;
					if (hdr_st != ST_HDR_OK) begin
						n_width = '0; n_height = '0;
						n_phase = PH_DONE;
					end else begin
						n_dims = 1'b1;
						if (id_left_q != 8'd0) n_phase = PH_ID;
						else go_mop = 1'b1;
					end
				end
			end
			PH_ID: begin
				n_id_left = id_left_q - 8'd1;
				if (id_left_q == 8'd1) go_mop = 1'b1;
			end
			PH_MAP: begin
				n_asm  = v;
				n_bidx = bidx_q + 2'd1;
				if ({1'b0, bidx_q} + 3'd1 >= peb_q) begin
					wd   = (peb_q >= 3'd3) ? {v[31:24], v[7:0], v[15:8], v[23:16]} : v;
					we_c = (32'(cnt_q) < 32'(MAP_ENTRIES));
					n_cnt = cnt_q + CNT_W'(1);
					n_asm = '0; n_bidx = '0;
					if (32'(cnt_q) + 32'd1 >= 32'(pal_len_q)) go_pix = 1'b1;
				end
			end
			PH_PKT: begin
				if (PIX_W'(cnt8) > pix_left_q) begin
					emit = 1'b1; st = ST_OVERFLOW; n_phase = PH_DONE;
				end else begin
					n_pkt_left = cnt8;
					n_pkt_run  = b[7];
					n_phase    = PH_PIX;
				end
			end
			PH_PIX: begin
				n_asm  = v;
				n_bidx = bidx_q + 2'd1;
				if ({1'b0, bidx_q} + 3'd1 >= bpp_q) begin
					emit = 1'b1;
					rl = pkt_run_q ? pkt_left_q : 8'd1;
					if (mapped) begin
						if (idx >= {1'b0, pal_len_q} || idx >= 17'(MAP_ENTRIES)) begin
							bad = 1'b1;
						end else begin
							lookup = 1'b1; re_c = 1'b1; cc = peb_q;
						end
					end else if (bpp_q == 3'd1) begin
						cc = 3'd1; ch0 = v[7:0];
					end else begin
						cc = bpp_q;
						ch0 = v[23:16]; ch1 = v[15:8]; ch2 = v[7:0];
						ch3 = (bpp_q == 3'd4) ? v[31:24] : 8'd0;
					end
					n_asm = '0; n_bidx = '0;
					if (bad) begin
						st = ST_BAD_INDEX; cc = '0; rl = '0;
						n_phase = PH_DONE;
					end else begin
						n_pix_left = (PIX_W'(rl) <= pix_left_q) ? pix_left_q - PIX_W'(rl) : '0;
						if (n_pix_left == '0) begin
							st = ST_FINAL; n_phase = PH_DONE;
						end else begin
							st = ST_RUN;
							if (kind_q >= 4'd9) begin
								if (pkt_run_q) begin
									n_phase = PH_PKT;
								end else begin
									n_pkt_left = pkt_left_q - 8'd1;
									if (pkt_left_q == 8'd1) n_phase = PH_PKT;
								end
							end
						end
					end
				end
			end
			PH_DONE: ;
			default: ;
		endcase

		go_map = go_mop && mapped;
		if (go_mop && !mapped) go_pix = 1'b1;
		if (go_map) begin
			n_phase = PH_MAP; n_cnt = '0; n_asm = '0; n_bidx = '0;
		end
		if (go_pix) begin
			n_pix_left = prod; n_asm = '0; n_bidx = '0; n_pkt_run = 1'b0; n_pkt_left = '0;
			n_phase = (kind_q >= 4'd9) ? PH_PKT : PH_PIX;
		end

		if (byte_in.end_of_file && n_phase != PH_DONE) begin
			emit = 1'b1; st = ST_TRUNC; cc = '0; rl = '0; lookup = 1'b0;
			ch0 = '0; ch1 = '0; ch2 = '0; ch3 = '0;
		end
		ow = n_dims ? n_width[14:0] : 15'd0;
		oh = n_dims ? n_height[14:0] : 15'd0;

		if (byte_in.end_of_file) begin
			n_phase = PH_HEADER; n_cnt = '0; n_kind = '0; n_id_left = '0;
			n_pal_first = '0; n_pal_len = '0; n_peb = '0; n_bpp = '0;
			n_width = '0; n_height = '0; n_asm = '0; n_bidx = '0;
			n_pkt_left = '0; n_pkt_run = 1'b0; n_pix_left = '0; n_dims = 1'b0;
		end
	end

	tgasd_ram #(.WIDTH(32), .DEPTH(MAP_ENTRIES)) u_palette (
		.clk   (clk),
		.we    (acc && we_c),
		.waddr (waddr),
		.wdata (wd),
		.re    (acc && re_c),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; cnt_q <= '0; kind_q <= '0; id_left_q <= '0;
			pal_first_q <= '0; pal_len_q <= '0; peb_q <= '0; bpp_q <= '0;
			width_q <= '0; height_q <= '0; asm_q <= '0; bidx_q <= '0;
			pkt_left_q <= '0; pkt_run_q <= 1'b0; pix_left_q <= '0; dims_q <= 1'b0;
		end else if (acc) begin
			phase_q <= n_phase; cnt_q <= n_cnt; kind_q <= n_kind; id_left_q <= n_id_left;
			pal_first_q <= n_pal_first; pal_len_q <= n_pal_len; peb_q <= n_peb;
			bpp_q <= n_bpp; width_q <= n_width; height_q <= n_height; asm_q <= n_asm;
			bidx_q <= n_bidx; pkt_left_q <= n_pkt_left; pkt_run_q <= n_pkt_run;
			pix_left_q <= n_pix_left; dims_q <= n_dims;
		end
	end

	assign s1_adv        = vld_s1 && (!vld_s2 || pixel_out.ready);
	assign byte_in.ready = !vld_s1 || !vld_s2 || pixel_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (acc) vld_s1 <= emit;
			else if (s1_adv) vld_s1 <= 1'b0;
			if (s1_adv) vld_s2 <= 1'b1;
			else if (pixel_out.ready) vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			st_s1 <= st; ch0_s1 <= ch0; ch1_s1 <= ch1; ch2_s1 <= ch2; ch3_s1 <= ch3;
			cc_s1 <= cc; rl_s1 <= rl; w_s1 <= ow; h_s1 <= oh; lk_s1 <= lookup;
		end
		if (s1_adv) begin
			st_s2 <= st_s1; cc_s2 <= cc_s1; rl_s2 <= rl_s1; w_s2 <= w_s1; h_s2 <= h_s1;
			if (lk_s1) begin
				ch0_s2 <= rdata[7:0];
				ch1_s2 <= (cc_s1 >= 3'd2) ? rdata[15:8] : 8'd0;
				ch2_s2 <= (cc_s1 >= 3'd3) ? rdata[23:16] : 8'd0;
				ch3_s2 <= (cc_s1 >= 3'd4) ? rdata[31:24] : 8'd0;
			end else begin
				ch0_s2 <= ch0_s1; ch1_s2 <= ch1_s1; ch2_s2 <= ch2_s1; ch3_s2 <= ch3_s1;
			end
		end
	end

	assign pixel_out.valid         = vld_s2;
	assign pixel_out.status        = st_s2;
	assign pixel_out.chan_zero     = ch0_s2;
	assign pixel_out.chan_one      = ch1_s2;
	assign pixel_out.chan_two      = ch2_s2;
	assign pixel_out.chan_three    = ch3_s2;
	assign pixel_out.channel_count = cc_s2;
	assign pixel_out.run_length    = rl_s2;
	assign pixel_out.image_width   = w_s2;
	assign pixel_out.image_height  = h_s2;

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && (st_s2 == ST_RUN || st_s2 == ST_FINAL) |-> rl_s2 != 8'd0)
		else $error("pixel word with zero run length");
	a_nonpix: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && st_s2 != ST_RUN && st_s2 != ST_FINAL |-> cc_s2 == 3'd0 && rl_s2 == 8'd0)
		else $error("status word carries pixel data");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_adv |=> vld_s1 && $stable(st_s1) && $stable(rl_s1))
		else $error("stalled stage-1 word lost");
	a_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && we_c && re_c))
		else $error("palette write and lookup in one cycle");
endmodule
